@@ rtl/assert_macros.svh @@
// Assertion macros used by bitmap_page_frame_allocator.sv.
// Each macro expands to one labeled concurrent assertion on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define AST_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/bpfa_pkg.sv @@
// Shared types and constants of the bitmap page frame allocator.
// No dependencies.
package bpfa_pkg;

  localparam int WORD_BITS = 64;
  localparam logic [31:0] MEM_BYTES_RESET = 32'h1000_0000;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FREE  = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

endpackage

@@ rtl/bitmap_page_frame_allocator.sv @@
// Bitmap page frame allocator, first fit. One 64-bit-wide synchronous map memory holds
// the used bits; an allocate scans it one word per cycle from word 0 and writes back the
// word with the found bit set, and a free reads the addressed word, then modifies and
// writes it back. Either result is registered and then moved to the output registers,
// and the next transfer is taken in the cycle the result appears. A result still waiting
// for out_ready holds the next result back and keeps in_ready low meanwhile.
// After reset and after every cfg write a clearing pass rewrites all (MAX_PAGE_COUNT+63)/64
// map words (1024 at default), one per cycle, with no input transfer taken meanwhile.
// Depends on bpfa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bitmap_page_frame_allocator #(
  parameter int MAX_PAGE_COUNT      = 65536,
  parameter int PAGE_BYTES          = 4096,
  parameter int RESERVED_PAGE_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_page_address,
  output logic [16:0] out_free_pages
);

  localparam int SHIFT     = $clog2(PAGE_BYTES);
  localparam int PN_W      = 32 - SHIFT;
  localparam int MAP_WORDS = (MAX_PAGE_COUNT + 63) / 64;
  localparam int IDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PC_W      = $clog2(MAX_PAGE_COUNT + 1);
  localparam int UC_MAX    = (MAX_PAGE_COUNT > RESERVED_PAGE_COUNT) ?
                             MAX_PAGE_COUNT : RESERVED_PAGE_COUNT;
  localparam int UC_W      = $clog2(UC_MAX + 1);
  localparam int CMP_W     = 34;
  localparam int WB        = bpfa_pkg::WORD_BITS;

  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_PAGE_COUNT);
  localparam logic [CMP_W-1:0] RES_C = CMP_W'(RESERVED_PAGE_COUNT);
  localparam logic [CMP_W-1:0] PC_RESET_RAW = CMP_W'(bpfa_pkg::MEM_BYTES_RESET >> SHIFT);
  localparam logic [PC_W-1:0]  PC_RESET = (PC_RESET_RAW > MAX_C) ?
                                          PC_W'(MAX_PAGE_COUNT) : PC_W'(PC_RESET_RAW);

  bpfa_pkg::state_t state_r, state_nxt;

  logic [WB-1:0]    map_mem [MAP_WORDS];
  logic [WB-1:0]    rd_data_r;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [WB-1:0]    wr_data;

  logic [PC_W-1:0]  page_count_r, page_count_nxt;
  logic [UC_W-1:0]  used_r, used_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [IDX_W:0]   cur_r, cur_nxt;
  logic [IDX_W-1:0] fword_r, fword_nxt;
  logic [5:0]       fbit_r, fbit_nxt;
  logic             fok_r, fok_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic [31:0]      res_addr_r, res_addr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [31:0]      out_addr_r, out_addr_nxt;
  logic [16:0]      out_free_r, out_free_nxt;

  logic [CMP_W-1:0] pc_c, base, lim, cbase, crem, cfg_pages, pidx, free_c;
  logic [PN_W-1:0]  pn;
  logic             pn_ok;
  logic [WB-1:0]    avail, vmask, clr_pat;
  logic [5:0]       hit_b;
  logic [IDX_W:0]   cur_inc;

  assign pc_c      = CMP_W'(page_count_r);
  assign base      = CMP_W'(cur_r) << 6;
  assign lim       = pc_c - base;
  assign cbase     = CMP_W'(clr_r) << 6;
  assign crem      = RES_C - cbase;
  assign cfg_pages = CMP_W'(cfg_write_data >> SHIFT);
  assign pn        = in_address[31:SHIFT];
  assign pn_ok     = (CMP_W'(pn) >= RES_C) && (CMP_W'(pn) < pc_c);
  assign cur_inc   = cur_r + 1'b1;
  assign pidx      = base | CMP_W'(hit_b);
  assign free_c    = (pc_c > CMP_W'(used_r)) ? (pc_c - CMP_W'(used_r)) : '0;

  always_comb begin
    vmask = (lim >= CMP_W'(WB)) ? '1 : ((WB'(1) << lim[5:0]) - WB'(1));
    avail = ~rd_data_r & vmask;
    hit_b = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (avail[b]) hit_b = 6'(b);
    end
  end

  always_comb begin
    if (cbase >= RES_C) begin
      clr_pat = '0;
    end else if (crem >= CMP_W'(WB)) begin
      clr_pat = '1;
    end else begin
      clr_pat = (WB'(1) << crem[5:0]) - WB'(1);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    page_count_nxt = page_count_r;
    used_nxt       = used_r;
    clr_nxt        = clr_r;
    cur_nxt        = cur_r;
    fword_nxt      = fword_r;
    fbit_nxt       = fbit_r;
    fok_nxt        = fok_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_free_nxt   = out_free_r;
    in_ready       = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = clr_r;
    wr_data        = clr_pat;

    unique case (state_r)
      bpfa_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IDX_W'(MAP_WORDS - 1)) state_nxt = bpfa_pkg::S_IDLE;
      end
      bpfa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == bpfa_pkg::MODE_ALLOC) begin
            rd_en     = 1'b1;
            cur_nxt   = '0;
            state_nxt = bpfa_pkg::S_SCAN;
          end else begin
            rd_en     = pn_ok;
            rd_addr   = IDX_W'(pn >> 6);
            fword_nxt = IDX_W'(pn >> 6);
            fbit_nxt  = pn[5:0];
            fok_nxt   = pn_ok;
            state_nxt = bpfa_pkg::S_FREE;
          end
        end
      end
      bpfa_pkg::S_SCAN: begin
        if (base >= pc_c) begin
          res_status_nxt = bpfa_pkg::ST_NO_FREE;
          res_addr_nxt   = '0;
          state_nxt      = bpfa_pkg::S_HOLD;
        end else if (|avail) begin
          wr_en          = 1'b1;
          wr_addr        = cur_r[IDX_W-1:0];
          wr_data        = rd_data_r | (WB'(1) << hit_b);
          used_nxt       = used_r + 1'b1;
          res_status_nxt = bpfa_pkg::ST_DONE;
          res_addr_nxt   = 32'(pidx << SHIFT);
          state_nxt      = bpfa_pkg::S_HOLD;
        end else begin
          cur_nxt = cur_inc;
          rd_en   = (cur_inc < (IDX_W+1)'(MAP_WORDS));
          rd_addr = cur_inc[IDX_W-1:0];
        end
      end
      bpfa_pkg::S_FREE: begin
        if (fok_r && rd_data_r[fbit_r]) begin
          wr_en          = 1'b1;
          wr_addr        = fword_r;
          wr_data        = rd_data_r & ~(WB'(1) << fbit_r);
          if (used_r != '0) used_nxt = used_r - 1'b1;
          res_status_nxt = bpfa_pkg::ST_DONE;
        end else begin
          res_status_nxt = bpfa_pkg::ST_IGNORED;
        end
        res_addr_nxt = '0;
        state_nxt    = bpfa_pkg::S_HOLD;
      end
      bpfa_pkg::S_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          out_free_nxt   = 17'(free_c);
          state_nxt      = bpfa_pkg::S_IDLE;
        end
      end
      default: state_nxt = bpfa_pkg::S_CLEAR;
    endcase

    if (cfg_write_en) begin
      page_count_nxt = (cfg_pages > MAX_C) ? PC_W'(MAX_PAGE_COUNT) : PC_W'(cfg_pages);
      used_nxt       = UC_W'(RESERVED_PAGE_COUNT);
      clr_nxt        = '0;
      state_nxt      = bpfa_pkg::S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bpfa_pkg::S_CLEAR;
      page_count_r <= PC_RESET;
      used_r       <= UC_W'(RESERVED_PAGE_COUNT);
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      page_count_r <= page_count_nxt;
      used_r       <= used_nxt;
      clr_r        <= clr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    fword_r      <= fword_nxt;
    fbit_r       <= fbit_nxt;
    fok_r        <= fok_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_page_address = out_addr_r;
  assign out_free_pages   = out_free_r;

  `AST_SAME(a_scan_wr, (state_r == bpfa_pkg::S_SCAN) && wr_en, base < pc_c, "scan past pages")
  `AST_SAME(a_used_bounded, 1'b1, CMP_W'(used_r) <= CMP_W'(UC_MAX), "used count too high")
  `AST_SAME(a_addr_zero, out_valid_r && (out_status_r != bpfa_pkg::ST_DONE), out_addr_r == '0, "bad addr")
  `AST_NEXT(a_accept_starts, in_valid && in_ready && !cfg_write_en, state_r != bpfa_pkg::S_IDLE, "no start")

endmodule
